// ===== rtl/core/mas_pkg.sv =====
// ----------------------------------------------------------------------------
// mas_pkg
// Types and fixed codes shared by the mailbox address splitter files.
// ----------------------------------------------------------------------------
`default_nettype none

package mas_pkg;

    // payload widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned DEST_W   = 2;
    localparam int unsigned STATUS_W = 3;

    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [DEST_W-1:0]   t_dest;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [1:0]          t_ctx;

    // destination codes
    localparam t_dest DEST_DROP    = 2'd0;
    localparam t_dest DEST_NAME    = 2'd1;
    localparam t_dest DEST_COMMENT = 2'd2;
    localparam t_dest DEST_ADDR    = 2'd3;

    // parse context codes
    localparam t_ctx CTX_TOP     = 2'd0;
    localparam t_ctx CTX_COMMENT = 2'd1;
    localparam t_ctx CTX_ANGLE   = 2'd2;

    // end-of-string status codes
    localparam t_status ST_OK           = 3'd0;
    localparam t_status ST_OPEN_QUOTE   = 3'd1;
    localparam t_status ST_OPEN_COMMENT = 3'd2;
    localparam t_status ST_OPEN_ANGLE   = 3'd3;
    localparam t_status ST_NO_ADDR      = 3'd4;
    localparam t_status ST_ADDR_FROM_NAME = 3'd5;

    // special characters
    localparam t_byte CH_NUL       = 8'h00;
    localparam t_byte CH_TAB       = 8'h09;
    localparam t_byte CH_CR        = 8'h0D;
    localparam t_byte CH_SPACE     = 8'h20;
    localparam t_byte CH_QUOTE     = 8'h22;
    localparam t_byte CH_LPAREN    = 8'h28;
    localparam t_byte CH_RPAREN    = 8'h29;
    localparam t_byte CH_COMMA     = 8'h2C;
    localparam t_byte CH_LANGLE    = 8'h3C;
    localparam t_byte CH_RANGLE    = 8'h3E;
    localparam t_byte CH_BACKSLASH = 8'h5C;

endpackage

`default_nettype wire

// ===== rtl/core/mas_in_if.sv =====
// ----------------------------------------------------------------------------
// mas_in_if
// Valid/ready channel carrying one byte of the mailbox string or an end mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface mas_in_if;
    logic           valid;
    logic           ready;
    mas_pkg::t_byte text_byte;
    logic           is_end;

    modport source (output valid, output text_byte, output is_end, input ready);
    modport sink   (input valid, input text_byte, input is_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mas_out_if.sv =====
// ----------------------------------------------------------------------------
// mas_out_if
// Valid/ready channel carrying one classified byte or the end status.
// ----------------------------------------------------------------------------
`default_nettype none

interface mas_out_if;
    logic             valid;
    logic             ready;
    mas_pkg::t_dest   dest;
    mas_pkg::t_byte   out_byte;
    logic             done_res;
    mas_pkg::t_status status;

    modport source (output valid, output dest, output out_byte, output done_res,
                    output status, input ready);
    modport sink   (input valid, input dest, input out_byte, input done_res,
                    input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mailbox_address_splitter_core.sv =====
// ----------------------------------------------------------------------------
// mailbox_address_splitter_core
// Byte-wise splitter of a mailbox string into display name, comment text and
// address spec, with an end-of-string status report.
// ----------------------------------------------------------------------------
// usage
//   i_in  : one transfer per string byte (text_byte), or an end mark (is_end)
//   o_out : exactly one transfer per input transfer, in order; dest/out_byte
//           say where the byte goes, done_res/status answer the end mark
//   a string is any run of byte transfers closed by one end transfer; the end
//   transfer returns the parser to its reset state for the next string
// timing
//   result valid is registered: the item goes into the input register, then
//   through the classifier and parser state update into the result register,
//   and only then can the result transfer take place; one item per cycle is
//   sustained while o_out.ready stays high, limited by the single parser
//   state update per clock
// reset
//   synchronous active-low i_rst_n empties both registers and clears the
//   parser state (top level, no quotes, no escape, depth zero)
// stall
//   while o_out.ready is low the result register holds; the input register
//   still takes one more transfer, then i_in.ready drops until space frees
// ----------------------------------------------------------------------------
`default_nettype none

module mailbox_address_splitter_core #(
    parameter int unsigned MAX_COMMENT_DEPTH = 255
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mas_in_if.sink      i_in,
    mas_out_if.source   o_out
);

    localparam int unsigned DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_COMMENT_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_ZERO = '0;

    // input register
    logic             r_in_valid;
    mas_pkg::t_byte   r_text_byte;
    logic             r_is_end;

    // result register
    logic             r_out_valid;
    mas_pkg::t_dest   r_dest;
    mas_pkg::t_byte   r_out_byte;
    logic             r_done_res;
    mas_pkg::t_status r_status;

    // parser state
    mas_pkg::t_ctx    r_context;
    logic             r_in_quotes;
    logic             r_escape;
    logic [DEPTH_W-1:0] r_depth;
    logic             r_stopped;
    logic             r_name_nonblank;
    logic             r_addr_nonblank;

    mas_pkg::t_ctx    n_context;
    logic             n_in_quotes;
    logic             n_escape;
    logic [DEPTH_W-1:0] n_depth;
    logic             n_stopped;
    logic             n_name_nonblank;
    logic             n_addr_nonblank;
    mas_pkg::t_dest   n_dest;
    mas_pkg::t_byte   n_out_byte;
    logic             n_done_res;
    mas_pkg::t_status n_status;

    mas_pkg::t_dest   ctx_dest;
    mas_pkg::t_status end_status;
    logic             ob_blank;
    logic [DEPTH_W-1:0] depth_dec;
    logic             advance;

    // the item in the input register moves on when the result slot is free
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid    = r_out_valid;
    assign o_out.dest     = r_dest;
    assign o_out.out_byte = r_out_byte;
    assign o_out.done_res = r_done_res;
    assign o_out.status   = r_status;

    // destination that follows the current context
    always_comb begin
        unique case (r_context)
            mas_pkg::CTX_COMMENT: ctx_dest = mas_pkg::DEST_COMMENT;
            mas_pkg::CTX_ANGLE:   ctx_dest = mas_pkg::DEST_ADDR;
            default:              ctx_dest = mas_pkg::DEST_NAME;
        endcase
    end

    // outcome of the string as it stands
    always_comb begin
        if (r_in_quotes) begin
            end_status = mas_pkg::ST_OPEN_QUOTE;
        end else if (r_context == mas_pkg::CTX_COMMENT) begin
            end_status = mas_pkg::ST_OPEN_COMMENT;
        end else if (r_context == mas_pkg::CTX_ANGLE) begin
            end_status = mas_pkg::ST_OPEN_ANGLE;
        end else if (!r_addr_nonblank) begin
            end_status = r_name_nonblank ? mas_pkg::ST_ADDR_FROM_NAME
                                         : mas_pkg::ST_NO_ADDR;
        end else begin
            end_status = mas_pkg::ST_OK;
        end
    end

    assign depth_dec = (r_depth != DEPTH_ZERO) ? r_depth - DEPTH_ONE : r_depth;

    // byte classifier and parser state update
    always_comb begin
        n_context       = r_context;
        n_in_quotes     = r_in_quotes;
        n_escape        = r_escape;
        n_depth         = r_depth;
        n_stopped       = r_stopped;
        n_name_nonblank = r_name_nonblank;
        n_addr_nonblank = r_addr_nonblank;
        n_dest          = mas_pkg::DEST_DROP;
        n_out_byte      = mas_pkg::CH_NUL;
        n_done_res      = 1'b0;
        n_status        = mas_pkg::ST_OK;

        if (r_is_end) begin
            // report and return to the reset state
            n_done_res      = 1'b1;
            n_status        = end_status;
            n_context       = mas_pkg::CTX_TOP;
            n_in_quotes     = 1'b0;
            n_escape        = 1'b0;
            n_depth         = DEPTH_ZERO;
            n_stopped       = 1'b0;
            n_name_nonblank = 1'b0;
            n_addr_nonblank = 1'b0;
        end else if (r_stopped) begin
            // everything dropped until the end mark
        end else if (r_text_byte == mas_pkg::CH_NUL) begin
            n_stopped = 1'b1;
        end else if (r_escape) begin
            n_escape   = 1'b0;
            n_dest     = ctx_dest;
            n_out_byte = r_text_byte;
        end else if (r_text_byte == mas_pkg::CH_BACKSLASH) begin
            n_escape   = 1'b1;
            n_dest     = ctx_dest;
            n_out_byte = r_text_byte;
        end else if (r_context == mas_pkg::CTX_COMMENT) begin
            n_dest     = mas_pkg::DEST_COMMENT;
            n_out_byte = r_text_byte;
            if (r_text_byte == mas_pkg::CH_LPAREN) begin
                if (r_depth < DEPTH_MAX) begin
                    n_depth = r_depth + DEPTH_ONE;
                end
            end else if (r_text_byte == mas_pkg::CH_RPAREN) begin
                n_depth = depth_dec;
                // outermost comment closes into a space
                if (depth_dec == DEPTH_ZERO) begin
                    n_context  = mas_pkg::CTX_TOP;
                    n_out_byte = mas_pkg::CH_SPACE;
                end
            end
        end else if (r_context == mas_pkg::CTX_ANGLE) begin
            if (r_text_byte == mas_pkg::CH_QUOTE) begin
                n_in_quotes = !r_in_quotes;
                n_dest      = mas_pkg::DEST_ADDR;
                n_out_byte  = r_text_byte;
            end else if (r_text_byte == mas_pkg::CH_RANGLE && !r_in_quotes) begin
                n_context = mas_pkg::CTX_TOP;
            end else begin
                n_dest     = mas_pkg::DEST_ADDR;
                n_out_byte = r_text_byte;
            end
        end else begin
            if (r_text_byte == mas_pkg::CH_QUOTE) begin
                n_in_quotes = !r_in_quotes;
                n_dest      = mas_pkg::DEST_NAME;
                n_out_byte  = r_text_byte;
            end else if (r_text_byte == mas_pkg::CH_LPAREN && !r_in_quotes) begin
                n_context = mas_pkg::CTX_COMMENT;
                n_depth   = DEPTH_ONE;
            end else if (r_text_byte == mas_pkg::CH_LANGLE && !r_in_quotes) begin
                n_context = mas_pkg::CTX_ANGLE;
            end else if (r_text_byte == mas_pkg::CH_COMMA && !r_in_quotes) begin
                // unquoted comma ends the parse
                n_stopped = 1'b1;
            end else begin
                n_dest     = mas_pkg::DEST_NAME;
                n_out_byte = r_text_byte;
            end
        end

        // space, tab, lf, vt, ff, cr
        ob_blank = (n_out_byte == mas_pkg::CH_SPACE) ||
                   (n_out_byte >= mas_pkg::CH_TAB && n_out_byte <= mas_pkg::CH_CR);

        if (!r_is_end) begin
            if (n_dest == mas_pkg::DEST_NAME && !ob_blank) begin
                n_name_nonblank = 1'b1;
            end
            if (n_dest == mas_pkg::DEST_ADDR && !ob_blank) begin
                n_addr_nonblank = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_context       <= mas_pkg::CTX_TOP;
            r_in_quotes     <= 1'b0;
            r_escape        <= 1'b0;
            r_depth         <= DEPTH_ZERO;
            r_stopped       <= 1'b0;
            r_name_nonblank <= 1'b0;
            r_addr_nonblank <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid     <= 1'b1;
                r_context       <= n_context;
                r_in_quotes     <= n_in_quotes;
                r_escape        <= n_escape;
                r_depth         <= n_depth;
                r_stopped       <= n_stopped;
                r_name_nonblank <= n_name_nonblank;
                r_addr_nonblank <= n_addr_nonblank;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_text_byte <= i_in.text_byte;
            r_is_end    <= i_in.is_end;
        end
        if (advance) begin
            r_dest     <= n_dest;
            r_out_byte <= n_out_byte;
            r_done_res <= n_done_res;
            r_status   <= n_status;
        end
    end

    // open comment always has a nonzero depth
    a_comment_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_context == mas_pkg::CTX_COMMENT |-> r_depth != DEPTH_ZERO)
        else $error("comment context with zero depth");

    // input side stalls only while holding an item
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_in_valid && r_out_valid && !o_out.ready)
        else $error("input stalled without a blocked item");

    // end report carries no byte
    a_end_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_done_res |->
            r_dest == mas_pkg::DEST_DROP && r_out_byte == mas_pkg::CH_NUL)
        else $error("end report carries a byte");

    // byte results carry no status
    a_byte_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_done_res |-> r_status == mas_pkg::ST_OK)
        else $error("status on a byte result");

    // end mark leaves the parser in its reset state
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_is_end |=>
            r_context == mas_pkg::CTX_TOP && !r_in_quotes && !r_escape &&
            !r_stopped && r_depth == DEPTH_ZERO)
        else $error("parser state not cleared after end mark");

endmodule

`default_nettype wire
